FILE: design/crc8pf_pkg.sv
// Package for the CRC-8 packet framer: field widths, frame constants,
// emission positions and the byte-wide CRC-8 update function.
// No dependencies.
package crc8pf_pkg;

    // Buffer size that bounds a whole frame (header, payload, trailer).
    localparam int TX_BUFFER_BYTES = 64;
    localparam int HEADER_BYTES    = 10;
    localparam int TRAILER_BYTES   = 2;

    // Stream widths.
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 8;

    // Frame constants.
    localparam logic [7:0] SOF_BYTE   = 8'h5B;
    localparam logic [7:0] EOF_BYTE   = 8'h5D;
    localparam logic [7:0] CRC_POLY   = 8'h31;
    localparam logic [7:0] PKT_NUM    = 8'h00;

    // Frame length as the header/trailer overhead plus the payload length.
    localparam logic [9:0] OVERHEAD_LEN = 10'(HEADER_BYTES + TRAILER_BYTES);
    localparam logic [9:0] BUFFER_LEN   = 10'(TX_BUFFER_BYTES);

    // Emission positions within one item's run of output bytes.
    typedef logic [3:0] pos_t;
    localparam pos_t POS_START   = 4'd0;
    localparam pos_t POS_PKT_LO  = 4'd1;
    localparam pos_t POS_PKT_HI  = 4'd4;
    localparam pos_t POS_TS_0    = 4'd5;
    localparam pos_t POS_TS_1    = 4'd6;
    localparam pos_t POS_TS_2    = 4'd7;
    localparam pos_t POS_TS_3    = 4'd8;
    localparam pos_t POS_CMD     = 4'd9;
    localparam pos_t POS_PAYLOAD = 4'd10;
    localparam pos_t POS_END     = 4'd11;
    localparam pos_t POS_CRC     = 4'd12;

    // CRC-8, polynomial 0x31, MSB first, one byte folded in.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++)
        begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

FILE: design/crc8_packet_framer.sv
// CRC-8 packet framer top level: frames payload bytes with a header, an end
// flag and a CRC-8 trailer. Depends on crc8pf_pkg.
//
//  Channel | Signals                              | Item
//  --------+--------------------------------------+-------------------------------
//  input   | s_tvalid s_tready s_tdata            | one payload byte + frame info
//  output  | m_tvalid m_tready m_tdata m_tlast    | one framed byte, tlast on CRC
//
// A frame's first item yields 11, 12 or 13 output bytes, one per cycle while
// the output is not stalled; a mid-frame payload item yields one byte, and
// the last one three (byte, end flag, CRC). The next item is taken in the
// cycle its predecessor's last byte leaves the emitter. Items of an oversize
// frame are consumed with no output. Reset clears the frame state, the
// emitter and the output register.
// A stall on m_tready holds the output register and, behind it, the emitter.
module crc8_packet_framer
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // [7:0] payload_byte, [15:8] payload_length, [23:16] command_id,
    // [55:24] time_stamp
    input  logic [crc8pf_pkg::IN_TDATA_W-1:0]      s_tdata,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // [7:0] tx_byte
    output logic [crc8pf_pkg::OUT_TDATA_W-1:0]     m_tdata,
    // frame_done
    output logic                                   m_tlast
);
    import crc8pf_pkg::*;

    // Input fields.
    logic [7:0]  payload_byte;
    logic [7:0]  payload_length;
    logic [7:0]  command_id;
    logic [31:0] time_stamp;

    assign payload_byte   = s_tdata[7:0];
    assign payload_length = s_tdata[15:8];
    assign command_id     = s_tdata[23:16];
    assign time_stamp     = s_tdata[55:24];

    // Frame state.
    logic [7:0] bytes_left_reg, bytes_left_next;
    logic       dropping_reg, dropping_next;
    logic [7:0] crc_reg;

    // Emitter job: the byte run owed for one accepted item.
    logic        job_valid_reg;
    pos_t        job_pos_reg;
    logic        job_payload_reg;
    logic        job_trailer_reg;
    logic [7:0]  job_byte_reg;
    logic [7:0]  job_cmd_reg;
    logic [31:0] job_ts_reg;

    // Output register.
    logic       m_valid_reg;
    logic [7:0] m_byte_reg;
    logic       m_last_reg;

    logic       s_accept;
    logic       emit;
    logic       job_end;
    pos_t       pos_next;
    logic [7:0] emit_byte;

    logic       new_job;
    pos_t       new_pos;
    logic       new_payload;
    logic       new_trailer;
    logic [9:0] frame_len;
    logic [7:0] bl_dec;

    // Emitter handshake: one byte per cycle whenever the output register frees up.
    assign emit     = job_valid_reg && (!m_valid_reg || m_tready);
    assign job_end  = (job_pos_reg == POS_CRC) ||
                      (job_pos_reg == POS_PAYLOAD && !job_trailer_reg);
    assign s_tready = !job_valid_reg || (emit && job_end);
    assign s_accept = s_tvalid && s_tready;

    // Next position, skipping the payload slot for an empty frame.
    always_comb
    begin
        if (job_pos_reg == POS_CMD && !job_payload_reg)
            pos_next = POS_END;
        else
            pos_next = job_pos_reg + 4'd1;
    end

    // Byte at the current position.
    always_comb
    begin
        if (job_pos_reg == POS_START)
            emit_byte = SOF_BYTE;
        else if (job_pos_reg >= POS_PKT_LO && job_pos_reg <= POS_PKT_HI)
            emit_byte = PKT_NUM;
        else if (job_pos_reg == POS_TS_0)
            emit_byte = job_ts_reg[7:0];
        else if (job_pos_reg == POS_TS_1)
            emit_byte = job_ts_reg[15:8];
        else if (job_pos_reg == POS_TS_2)
            emit_byte = job_ts_reg[23:16];
        else if (job_pos_reg == POS_TS_3)
            emit_byte = job_ts_reg[31:24];
        else if (job_pos_reg == POS_CMD)
            emit_byte = job_cmd_reg;
        else if (job_pos_reg == POS_PAYLOAD)
            emit_byte = job_byte_reg;
        else if (job_pos_reg == POS_END)
            emit_byte = EOF_BYTE;
        else
            emit_byte = crc_reg;
    end

    // Frame bookkeeping for an accepted item and the job it opens, if any.
    assign frame_len = OVERHEAD_LEN + {2'b00, payload_length};
    assign bl_dec    = bytes_left_reg - 8'd1;

    always_comb
    begin
        bytes_left_next = bytes_left_reg;
        dropping_next   = dropping_reg;
        new_job         = 1'b0;
        new_pos         = POS_PAYLOAD;
        new_payload     = 1'b1;
        new_trailer     = 1'b0;
        if (bytes_left_reg != 8'd0)
        begin
            // Mid-frame item: pass the byte through or discard it.
            bytes_left_next = bl_dec;
            if (dropping_reg)
            begin
                if (bl_dec == 8'd0)
                    dropping_next = 1'b0;
            end
            else
            begin
                new_job     = 1'b1;
                new_trailer = (bl_dec == 8'd0);
            end
        end
        else if (frame_len > BUFFER_LEN)
        begin
            // Oversize frame: swallow its remaining items.
            if (payload_length > 8'd1)
            begin
                bytes_left_next = payload_length - 8'd1;
                dropping_next   = 1'b1;
            end
        end
        else
        begin
            // First item of a frame: header, then payload and trailer as due.
            new_job         = 1'b1;
            new_pos         = POS_START;
            new_payload     = (payload_length != 8'd0);
            new_trailer     = (payload_length <= 8'd1);
            bytes_left_next = (payload_length == 8'd0) ? 8'd0 : payload_length - 8'd1;
        end
    end

    // Frame state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_left_reg <= 8'd0;
            dropping_reg   <= 1'b0;
        end
        else if (s_accept)
        begin
            bytes_left_reg <= bytes_left_next;
            dropping_reg   <= dropping_next;
        end
    end

    // Running CRC over the emitted bytes; cleared as the CRC byte leaves.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            crc_reg <= 8'd0;
        else if (emit)
        begin
            if (job_pos_reg == POS_CRC)
                crc_reg <= 8'd0;
            else
                crc_reg <= crc8_byte(crc_reg, emit_byte);
        end
    end

    // Emitter job control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg   <= 1'b0;
            job_pos_reg     <= POS_START;
            job_payload_reg <= 1'b0;
            job_trailer_reg <= 1'b0;
        end
        else if (s_accept)
        begin
            job_valid_reg   <= new_job;
            job_pos_reg     <= new_pos;
            job_payload_reg <= new_payload;
            job_trailer_reg <= new_trailer;
        end
        else if (emit)
        begin
            if (job_end)
                job_valid_reg <= 1'b0;
            else
                job_pos_reg <= pos_next;
        end
    end

    // Emitter job payload.
    always_ff @(posedge clk)
    begin
        if (s_accept && new_job)
        begin
            job_byte_reg <= payload_byte;
            if (bytes_left_reg == 8'd0)
            begin
                job_cmd_reg <= command_id;
                job_ts_reg  <= time_stamp;
            end
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (emit)
            m_valid_reg <= 1'b1;
        else if (m_tready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            m_byte_reg <= emit_byte;
            m_last_reg <= (job_pos_reg == POS_CRC);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_byte_reg;
    assign m_tlast  = m_last_reg;

endmodule
